// ===== hdl/gssfd_pkg.sv =====
// gssfd_pkg: shared types and constants for the gap synced servo frame deframer
// no dependencies; used by every module of the block by scoped names
package gssfd_pkg;

    // field and register widths
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 16;
    localparam int POS_W     = 6;
    localparam int DONE_W    = 5;
    localparam int INDEX_W   = 4;
    localparam int FRAME_W   = 8;
    localparam int RAW_W     = 16;
    localparam int GAIN_W    = 10;
    localparam int VALUE_W   = 26;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // last byte position of a frame; the position counter saturates here
    localparam logic [POS_W-1:0] BUFFER_LAST = 6'd49;

    // reset values of the configuration registers
    localparam logic [TIME_W-1:0] RESET_THRESHOLD = 16'd500;
    localparam logic [GAIN_W-1:0] RESET_GAIN      = 10'd1;

    // header flag bit positions
    localparam int HDR_FAST_OFF_BIT = 1;
    localparam int HDR_FAILSAFE_BIT = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_THRESHOLD = 1'b0,
        CFG_CHANNEL_GAIN  = 1'b1
    } t_cfg_index;

    // one decoded channel before gain scaling
    typedef struct packed {
        logic signed [RAW_W-1:0]  raw;
        logic [INDEX_W-1:0]       index;
        logic                     rapid_mode_off;
        logic                     failsafe_request;
        logic [FRAME_W-1:0]       frame_number;
        logic                     last_channel;
    } t_chan_item;

endpackage

// ===== hdl/gssfd_frame_tracker.sv =====
// gssfd_frame_tracker: gap detection, byte position and channel assembly state
// depends on gssfd_pkg
module gssfd_frame_tracker #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [gssfd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic [gssfd_pkg::TIME_W-1:0]      i_arrival_time_us,
    input  logic [gssfd_pkg::TIME_W-1:0]      i_gap_threshold_us,
    output logic                              o_emit,
    output gssfd_pkg::t_chan_item             o_item
);

    localparam logic [gssfd_pkg::DONE_W-1:0] MAX_DONE =
        gssfd_pkg::DONE_W'(NUM_CHANNELS);
    localparam logic [gssfd_pkg::DONE_W-1:0] LAST_IDX =
        gssfd_pkg::DONE_W'(NUM_CHANNELS - 1);

    logic [gssfd_pkg::TIME_W-1:0]  r_prev_time;
    logic [gssfd_pkg::POS_W-1:0]   r_pos;
    logic [gssfd_pkg::BYTE_W-1:0]  r_header;
    logic [gssfd_pkg::BYTE_W-1:0]  r_low;
    logic [gssfd_pkg::DONE_W-1:0]  r_done;
    logic [gssfd_pkg::FRAME_W-1:0] r_frame;

    logic [gssfd_pkg::TIME_W-1:0]  gap;
    logic                          new_frame;
    logic [gssfd_pkg::POS_W-1:0]   pos_cur;
    logic [gssfd_pkg::DONE_W-1:0]  done_cur;
    logic [gssfd_pkg::FRAME_W-1:0] n_frame;
    logic [gssfd_pkg::POS_W-1:0]   n_pos;
    logic                          is_header;
    logic                          is_low;

    always_comb begin
        gap       = i_arrival_time_us - r_prev_time;
        new_frame = gap > i_gap_threshold_us;
        pos_cur   = new_frame ? '0 : r_pos;
        done_cur  = new_frame ? '0 : r_done;
        n_frame   = r_frame + gssfd_pkg::FRAME_W'(new_frame);
        n_pos     = (pos_cur < gssfd_pkg::BUFFER_LAST) ? pos_cur + 1'b1 : pos_cur;
        is_header = pos_cur == '0;
        is_low    = !is_header && pos_cur[0];
        o_emit    = !is_header && !is_low && (done_cur < MAX_DONE);

        o_item.raw               = {i_rx_byte, r_low};
        o_item.index             = done_cur[gssfd_pkg::INDEX_W-1:0];
        o_item.rapid_mode_off    = r_header[gssfd_pkg::HDR_FAST_OFF_BIT];
        o_item.failsafe_request  = r_header[gssfd_pkg::HDR_FAILSAFE_BIT];
        o_item.frame_number      = n_frame;
        o_item.last_channel      = done_cur == LAST_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_pos       <= '0;
            r_header    <= '0;
            r_low       <= '0;
            r_done      <= '0;
            r_frame     <= '0;
        end else if (i_fire) begin
            r_prev_time <= i_arrival_time_us;
            r_pos       <= n_pos;
            r_frame     <= n_frame;
            if (is_header) begin
                r_header <= i_rx_byte;
            end
            if (is_low) begin
                r_low <= i_rx_byte;
            end
            r_done <= o_emit ? done_cur + 1'b1 : done_cur;
        end
    end

endmodule

// ===== hdl/gssfd_scaler.sv =====
// gssfd_scaler: gain multiply and result register of the output channel
// depends on gssfd_pkg
module gssfd_scaler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  gssfd_pkg::t_chan_item                i_item,
    input  logic [gssfd_pkg::GAIN_W-1:0]         i_gain,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [gssfd_pkg::INDEX_W-1:0]        o_channel_index,
    output logic signed [gssfd_pkg::VALUE_W-1:0] o_channel_value,
    output logic                                 o_rapid_mode_off,
    output logic                                 o_failsafe_request,
    output logic [gssfd_pkg::FRAME_W-1:0]        o_frame_number,
    output logic                                 o_last_channel
);

    localparam int PROD_W = gssfd_pkg::RAW_W + gssfd_pkg::GAIN_W + 1;

    logic                         r_valid;
    logic signed [PROD_W-1:0]     product;
    logic signed [gssfd_pkg::GAIN_W:0] gain_s;

    assign gain_s  = $signed({1'b0, i_gain});
    assign product = PROD_W'(i_item.raw) * PROD_W'(gain_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload carries no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_channel_index     <= i_item.index;
            o_channel_value     <= product[gssfd_pkg::VALUE_W-1:0];
            o_rapid_mode_off    <= i_item.rapid_mode_off;
            o_failsafe_request  <= i_item.failsafe_request;
            o_frame_number      <= i_item.frame_number;
            o_last_channel      <= i_item.last_channel;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// ===== hdl/gap_synced_servo_frame_deframer.sv =====
// gap_synced_servo_frame_deframer: top level, input register, channel stage, config
// depends on gssfd_pkg, gssfd_frame_tracker, gssfd_scaler
//
// channel | handshake                   | payload
// --------+-----------------------------+------------------------------------------
// in      | i_in_valid / o_in_ready     | i_rx_byte, i_arrival_time_us
// out     | o_out_valid / i_out_ready   | o_channel_index, o_channel_value, flags,
//         |                             | o_frame_number, o_last_channel
// cfg     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the output does not stall; three register stages
// (input, channel, result); the input register loads at the transfer edge, and the
// byte then passes through the channel stage and the result register in turn
// the frame state updates once per byte as it leaves the input register
// reset is synchronous: frame state and all stage valids are cleared, the
// configuration registers take their reset values
// a stall on the output backs up stage by stage; each stage loads whenever
// the one after it is empty or moving, so no bubble appears under full flow
module gap_synced_servo_frame_deframer #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [gssfd_pkg::BYTE_W-1:0]           i_rx_byte,
    input  logic [gssfd_pkg::TIME_W-1:0]           i_arrival_time_us,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [gssfd_pkg::INDEX_W-1:0]          o_channel_index,
    output logic signed [gssfd_pkg::VALUE_W-1:0]   o_channel_value,
    output logic                                   o_rapid_mode_off,
    output logic                                   o_failsafe_request,
    output logic [gssfd_pkg::FRAME_W-1:0]          o_frame_number,
    output logic                                   o_last_channel,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [gssfd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gssfd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // configuration registers
    logic [gssfd_pkg::TIME_W-1:0] r_gap_threshold;
    logic [gssfd_pkg::GAIN_W-1:0] r_gain;

    // input register stage
    logic                          r_in_valid;
    logic [gssfd_pkg::BYTE_W-1:0]  r_rx_byte;
    logic [gssfd_pkg::TIME_W-1:0]  r_arrival_time;

    // channel stage between tracker and scaler
    logic                          r_chan_valid;
    gssfd_pkg::t_chan_item         r_chan_item;

    logic                          out_free;
    logic                          chan_free;
    logic                          byte_fire;
    logic                          emit;
    gssfd_pkg::t_chan_item         item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_threshold <= gssfd_pkg::RESET_THRESHOLD;
            r_gain          <= gssfd_pkg::RESET_GAIN;
        end else if (i_cfg_we) begin
            case (gssfd_pkg::t_cfg_index'(i_cfg_index))
                gssfd_pkg::CFG_GAP_THRESHOLD: begin
                    r_gap_threshold <= i_cfg_data[gssfd_pkg::TIME_W-1:0];
                end
                gssfd_pkg::CFG_CHANNEL_GAIN: begin
                    r_gain <= i_cfg_data[gssfd_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage advance: a stage may load when it is empty or its content moves on
    assign out_free   = !o_out_valid || i_out_ready;
    assign chan_free  = !r_chan_valid || out_free;
    assign byte_fire  = r_in_valid && chan_free;
    assign o_in_ready = !r_in_valid || chan_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_rx_byte      <= i_rx_byte;
            r_arrival_time <= i_arrival_time_us;
        end
    end

    gssfd_frame_tracker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_tracker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (byte_fire),
        .i_rx_byte          (r_rx_byte),
        .i_arrival_time_us  (r_arrival_time),
        .i_gap_threshold_us (r_gap_threshold),
        .o_emit             (emit),
        .o_item             (item)
    );

    // bytes that decode no channel (header, low bytes, past the limit) drop here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_valid <= 1'b0;
        end else if (chan_free) begin
            r_chan_valid <= byte_fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chan_free) begin
            r_chan_item <= item;
        end
    end

    gssfd_scaler u_scaler (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (r_chan_valid && out_free),
        .i_item              (r_chan_item),
        .i_gain              (r_gain),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_channel_index     (o_channel_index),
        .o_channel_value     (o_channel_value),
        .o_rapid_mode_off    (o_rapid_mode_off),
        .o_failsafe_request  (o_failsafe_request),
        .o_frame_number      (o_frame_number),
        .o_last_channel      (o_last_channel)
    );

endmodule

// ===== hdl/gssfd_checker.sv =====
// gssfd_checker: port level assertions for the deframer, bound to the top level
// depends on gap_synced_servo_frame_deframer and gssfd_pkg
module gssfd_checker #(
    parameter int NUM_CHANNELS = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [gssfd_pkg::INDEX_W-1:0]        o_channel_index,
    input logic                                 o_last_channel
);

    localparam logic [gssfd_pkg::INDEX_W-1:0] LAST_IDX =
        gssfd_pkg::INDEX_W'(NUM_CHANNELS - 1);

    // a pending result is held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // no result comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // the last channel flag marks exactly the final allowed index
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_channel == (o_channel_index == LAST_IDX)))
        else $error("last channel flag does not match index");

    // channel index never passes the per frame limit
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_channel_index <= LAST_IDX)
        else $error("channel index beyond channel limit");

endmodule

bind gap_synced_servo_frame_deframer gssfd_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_gssfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_channel_index (o_channel_index),
    .o_last_channel  (o_last_channel)
);

// ===== bench/gap_synced_servo_frame_deframer_tb.sv =====
// gap_synced_servo_frame_deframer_tb: self-checking bench for the servo frame deframer
// depends on gssfd_pkg and gap_synced_servo_frame_deframer
// a directed table runs first, then random frames under three idle patterns
module gap_synced_servo_frame_deframer_tb;

    localparam int BYTE_W     = gssfd_pkg::BYTE_W;
    localparam int TIME_W     = gssfd_pkg::TIME_W;
    localparam int POS_W      = gssfd_pkg::POS_W;
    localparam int DONE_W     = gssfd_pkg::DONE_W;
    localparam int INDEX_W    = gssfd_pkg::INDEX_W;
    localparam int FRAME_W    = gssfd_pkg::FRAME_W;
    localparam int RAW_W      = gssfd_pkg::RAW_W;
    localparam int GAIN_W     = gssfd_pkg::GAIN_W;
    localparam int VALUE_W    = gssfd_pkg::VALUE_W;
    localparam int CFG_IDX_W  = gssfd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = gssfd_pkg::CFG_DATA_W;

    localparam int NUM_CHANNELS = 16;
    localparam int CLK_PERIOD   = 8;
    // byte position where the frame position counter stops
    localparam int POS_LAST     = 49;
    localparam int SEGMENTS     = 6;
    localparam int SEG_BYTES    = 270;
    // quiet cycles after the last channel, covers bytes still in the pipe
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    // one decoded channel as it leaves the block
    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      fast_off;
        logic                      failsafe;
        logic [FRAME_W-1:0]        frame;
        logic                      last;
    } t_chan_result;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_THRESHOLD,
        ROW_SET_GAIN
    } t_row_kind;

    // directed row: a byte with its timestamp, or a register write (data in stamp)
    typedef struct packed {
        t_row_kind          kind;
        logic [BYTE_W-1:0]  rx;
        logic [TIME_W-1:0]  stamp;
        logic               typed;
        t_chan_result       want;
    } t_row;

    // dut ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [BYTE_W-1:0]         i_rx_byte = '0;
    logic [TIME_W-1:0]         i_arrival_time_us = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [INDEX_W-1:0]        o_channel_index;
    logic signed [VALUE_W-1:0] o_channel_value;
    logic                      o_rapid_mode_off;
    logic                      o_failsafe_request;
    logic [FRAME_W-1:0]        o_frame_number;
    logic                      o_last_channel;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // deframer state as the bench tracks it, starting from reset values
    logic [TIME_W-1:0]  gap_limit = 16'd500;
    logic [GAIN_W-1:0]  gain = 10'd1;
    logic [TIME_W-1:0]  last_stamp = '0;
    logic [POS_W-1:0]   frame_pos = '0;
    logic [BYTE_W-1:0]  header = '0;
    logic [BYTE_W-1:0]  low_half = '0;
    logic [DONE_W-1:0]  chans_out = '0;
    logic [FRAME_W-1:0] frame_cnt = '0;

    // channels predicted but not yet seen on the output
    t_chan_result pending_channels[$];

    int in_idle_pct = 33;
    int out_stall_pct = 77;
    int bytes_sent = 0;
    int mismatch_count = 0;
    // running microsecond clock of the random stream, wraps like the real one
    logic [TIME_W-1:0] clock_us = '0;

    // directed table: header flags, extremes of value and gain, gap equal to the
    // threshold, timestamp wrap, zero threshold and masked gain writes
    t_row dir_rows [24] = '{
        // stream before any gap: position 0 is a header, frame number stays 0
        '{ROW_BYTE, 8'h06, 16'd10,  1'b0, '0},
        '{ROW_BYTE, 8'hFF, 16'd20,  1'b0, '0},
        '{ROW_BYTE, 8'h7F, 16'd30,  1'b1, '{4'd0, 26'sd32767, 1'b1, 1'b1, 8'd0, 1'b0}},
        '{ROW_BYTE, 8'h00, 16'd40,  1'b0, '0},
        // gap exactly 500 keeps the frame going
        '{ROW_BYTE, 8'h80, 16'd540, 1'b1, '{4'd1, -26'sd32768, 1'b1, 1'b1, 8'd0, 1'b0}},
        // gap 501 opens frame 1
        '{ROW_BYTE, 8'h00, 16'd1041, 1'b0, '0},
        '{ROW_BYTE, 8'h01, 16'd1050, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 16'd1060, 1'b1, '{4'd0, 26'sd1, 1'b0, 1'b0, 8'd1, 1'b0}},
        // frame 2 at the top of the timestamp range, then wrap to 0
        '{ROW_BYTE, 8'h02, 16'hFFFF, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 16'd0,    1'b0, '0},
        '{ROW_BYTE, 8'hFF, 16'd5,    1'b1, '{4'd0, -26'sd1, 1'b1, 1'b0, 8'd2, 1'b0}},
        // gain 1023 from an all-ones write, threshold 0
        '{ROW_SET_GAIN,      8'h00, 16'hFFFF, 1'b0, '0},
        '{ROW_SET_THRESHOLD, 8'h00, 16'd0,    1'b0, '0},
        '{ROW_BYTE, 8'h04, 16'd100, 1'b0, '0},
        // zero gap never opens a frame
        '{ROW_BYTE, 8'h00, 16'd100, 1'b0, '0},
        '{ROW_BYTE, 8'h80, 16'd100, 1'b1,
          '{4'd0, -26'sd33521664, 1'b0, 1'b1, 8'd3, 1'b0}},
        '{ROW_BYTE, 8'hFF, 16'd100, 1'b0, '0},
        '{ROW_BYTE, 8'h7F, 16'd100, 1'b1,
          '{4'd1, 26'sd33520641, 1'b0, 1'b1, 8'd3, 1'b0}},
        // gain 0, only bits above the register are set
        '{ROW_SET_GAIN, 8'h00, 16'hFC00, 1'b0, '0},
        '{ROW_BYTE, 8'h55, 16'd100, 1'b0, '0},
        '{ROW_BYTE, 8'hAA, 16'd100, 1'b1, '{4'd2, 26'sd0, 1'b0, 1'b1, 8'd3, 1'b0}},
        // top threshold: the largest gap does not exceed it
        '{ROW_SET_THRESHOLD, 8'h00, 16'hFFFF, 1'b0, '0},
        '{ROW_BYTE, 8'h12, 16'd0,    1'b0, '0},
        '{ROW_BYTE, 8'h34, 16'hFFFF, 1'b0, '0}
    };

    gap_synced_servo_frame_deframer #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .i_arrival_time_us   (i_arrival_time_us),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_channel_index     (o_channel_index),
        .o_channel_value     (o_channel_value),
        .o_rapid_mode_off    (o_rapid_mode_off),
        .o_failsafe_request  (o_failsafe_request),
        .o_frame_number      (o_frame_number),
        .o_last_channel      (o_last_channel),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // advance the tracked frame state by one byte; returns 1 when a channel comes out
    function automatic bit decode_byte(input logic [BYTE_W-1:0] rx,
                                       input logic [TIME_W-1:0] stamp,
                                       output t_chan_result res);
        logic [TIME_W-1:0]       gap;
        logic [POS_W-1:0]        pos;
        logic signed [RAW_W-1:0] raw;
        int                      product;
        // gap wraps at 16 bits with the timestamp
        gap = stamp - last_stamp;
        last_stamp = stamp;
        res = '0;
        if (gap > gap_limit) begin
            frame_pos = '0;
            chans_out = '0;
            frame_cnt = frame_cnt + 1'b1;
        end
        pos = frame_pos;
        if (frame_pos < POS_LAST) begin
            frame_pos = frame_pos + 1'b1;
        end
        if (pos == 0) begin
            header = rx;
            return 1'b0;
        end
        // odd positions carry the low byte of the next channel
        if (pos[0]) begin
            low_half = rx;
            return 1'b0;
        end
        if (chans_out >= NUM_CHANNELS) begin
            return 1'b0;
        end
        raw = {rx, low_half};
        product = int'(raw) * int'(gain);
        res.index = chans_out[INDEX_W-1:0];
        res.value = product[VALUE_W-1:0];
        res.fast_off = header[1];
        res.failsafe = header[2];
        res.frame = frame_cnt;
        res.last = (chans_out == NUM_CHANNELS - 1);
        chans_out = chans_out + 1'b1;
        return 1'b1;
    endfunction

    // present one byte, hold it until the transfer, record the channel it yields
    // entered and left at a falling edge
    task automatic put_byte(input logic [BYTE_W-1:0] rx, input logic [TIME_W-1:0] stamp,
                            input bit typed, input t_chan_result want);
        t_chan_result got;
        bit           produced;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = rx;
        i_arrival_time_us = stamp;
        do @(posedge i_clk); while (!o_in_ready);
        produced = decode_byte(rx, stamp, got);
        // typed rows carry a hand-written channel in place of the prediction
        if (typed) begin
            pending_channels.push_back(want);
        end else if (produced) begin
            pending_channels.push_back(got);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input gssfd_pkg::t_cfg_index idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid = 1'b0;
        while (pending_channels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == gssfd_pkg::CFG_GAP_THRESHOLD) begin
            gap_limit = data;
        end else begin
            gain = data[GAIN_W-1:0];
        end
    endtask

    // one frame with random content; broken frames get random length and gaps
    task automatic send_frame(input bit broken);
        int          nbytes;
        int unsigned step;
        // opening gap just above the threshold now and then
        if (broken || gap_limit == 16'hFFFF) begin
            step = $urandom_range(0, 65535);
        end else if ($urandom_range(0, 7) == 0) begin
            step = int'(gap_limit) + 1;
        end else begin
            step = $urandom_range(int'(gap_limit) + 1, 65535);
        end
        if (broken) begin
            nbytes = $urandom_range(1, 12);
        end else if ($urandom_range(0, 7) == 0) begin
            // long frame, runs past the channel limit and at times into the saturated position
            nbytes = $urandom_range(34, 60);
        end else begin
            nbytes = 1 + 2 * $urandom_range(1, NUM_CHANNELS);
        end
        for (int k = 0; k < nbytes; k++) begin
            if (k != 0) begin
                if (broken) begin
                    step = $urandom_range(0, 65535);
                end else if ($urandom_range(0, 15) == 0) begin
                    step = gap_limit;
                end else begin
                    step = $urandom_range(0, gap_limit);
                end
            end
            clock_us = clock_us + step[TIME_W-1:0];
            put_byte(8'($urandom_range(0, 255)), clock_us, 1'b0, '0);
        end
    endtask

    // receiver side: random stalls per cycle
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= out_stall_pct);
    end

    // every channel transfer is checked against the oldest pending channel
    always @(posedge i_clk) begin
        t_chan_result oldest;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_channels.size() == 0) begin
                $error("channel transfer with none pending: index %0d value %0d",
                       o_channel_index, o_channel_value);
                mismatch_count++;
            end else begin
                oldest = pending_channels.pop_front();
                if (o_channel_index !== oldest.index) begin
                    $error("channel_index: expected %0d, got %0d",
                           oldest.index, o_channel_index);
                    mismatch_count++;
                end
                if (o_channel_value !== oldest.value) begin
                    $error("channel_value: expected %0d, got %0d",
                           oldest.value, o_channel_value);
                    mismatch_count++;
                end
                if (o_rapid_mode_off !== oldest.fast_off) begin
                    $error("rapid_mode_off: expected %0d, got %0d",
                           oldest.fast_off, o_rapid_mode_off);
                    mismatch_count++;
                end
                if (o_failsafe_request !== oldest.failsafe) begin
                    $error("failsafe_request: expected %0d, got %0d",
                           oldest.failsafe, o_failsafe_request);
                    mismatch_count++;
                end
                if (o_frame_number !== oldest.frame) begin
                    $error("frame_number: expected %0d, got %0d",
                           oldest.frame, o_frame_number);
                    mismatch_count++;
                end
                if (o_last_channel !== oldest.last) begin
                    $error("last_channel: expected %0d, got %0d",
                           oldest.last, o_last_channel);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_row                  row;
        int                    target;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] gn;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows under the first idle pattern
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            case (row.kind)
                ROW_BYTE: begin
                    put_byte(row.rx, row.stamp, row.typed, row.want);
                end
                ROW_SET_THRESHOLD: begin
                    write_reg(gssfd_pkg::CFG_GAP_THRESHOLD, row.stamp);
                end
                default: begin
                    write_reg(gssfd_pkg::CFG_CHANNEL_GAIN, row.stamp);
                end
            endcase
        end
        clock_us = last_stamp;

        // random segments, two per idle pattern, each with its own settings
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    thr = 16'd50;
                    gn = 16'hFFFF;
                end
                1: begin
                    thr = 16'd0;
                    gn = 16'd0;
                end
                2: begin
                    // only the widest gap opens a frame
                    thr = 16'hFFFE;
                    gn = 16'd517;
                end
                3: begin
                    thr = 16'($urandom_range(0, 65535));
                    gn = 16'($urandom_range(0, 65535));
                end
                4: begin
                    thr = 16'd500;
                    gn = 16'd1;
                end
                default: begin
                    thr = 16'($urandom_range(0, 4000));
                    gn = 16'($urandom_range(0, 65535));
                end
            endcase
            write_reg(gssfd_pkg::CFG_GAP_THRESHOLD, thr);
            write_reg(gssfd_pkg::CFG_CHANNEL_GAIN, gn);
            if (seg < 2) begin
                in_idle_pct = 33;
                out_stall_pct = 77;
            end else if (seg < 4) begin
                in_idle_pct = 77;
                out_stall_pct = 33;
            end else begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
            target = bytes_sent + SEG_BYTES;
            while (bytes_sent < target) begin
                send_frame($urandom_range(0, 9) >= 8);
            end
        end

        // wait for the last channels, then a few quiet cycles
        i_in_valid = 1'b0;
        while (pending_channels.size() != 0) @(negedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("gap_synced_servo_frame_deframer: match");
        end else begin
            $display("gap_synced_servo_frame_deframer: mismatch");
        end
        $finish;
    end

    // hard stop if the stream or the output hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("gap_synced_servo_frame_deframer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gssfd_pkg.sv
hdl/gssfd_frame_tracker.sv
hdl/gssfd_scaler.sv
hdl/gap_synced_servo_frame_deframer.sv
hdl/gssfd_checker.sv
bench/gap_synced_servo_frame_deframer_tb.sv
